// ===== rtl/fup_pkg.sv =====
// shared types, constants and helpers of the fast-path update parser
package fup_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam int LEN_W           = 15;
    localparam int IDX_W           = 6;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_LEN1,
        PH_LEN2,
        PH_REC,
        PH_FLAGS,
        PH_SZLO,
        PH_SZHI,
        PH_PAY,
        PH_SECWAIT,
        PH_DONE,
        PH_ERR
    } fup_phase_t;

    // byte roles
    localparam logic [2:0] ROLE_PKT_HDR  = 3'd0;
    localparam logic [2:0] ROLE_REC_HDR  = 3'd1;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd2;
    localparam logic [2:0] ROLE_TRAILING = 3'd3;
    localparam logic [2:0] ROLE_IGNORED  = 3'd4;

    // packet outcome
    localparam logic [1:0] ST_BUSY      = 2'd0;
    localparam logic [1:0] ST_OK        = 2'd1;
    localparam logic [1:0] ST_PROTO_ERR = 2'd2;
    localparam logic [1:0] ST_SECURITY  = 2'd3;

    // protocol field values
    localparam logic [1:0] ACTION_FASTPATH = 2'd0;
    localparam logic [1:0] COMP_USED       = 2'd2;
    localparam logic [1:0] FRAG_SINGLE     = 2'd0;
    localparam logic [3:0] CODE_SYNC       = 4'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } fup_in_t;

    typedef struct packed {
        logic [2:0]       byte_role;
        logic [7:0]       passed_byte;
        logic [IDX_W-1:0] record_index;
        logic             descriptor_ready;
        logic [3:0]       update_kind;
        logic [1:0]       fragment_mode;
        logic             is_compressed;
        logic [7:0]       compress_flags;
        logic [LEN_W-1:0] payload_size;
        logic [1:0]       packet_status;
    } fup_out_t;

    // byte after classification, as held in the queue
    typedef struct packed {
        logic [7:0] in_byte;
        logic       eob;
        logic       action_bad;
        logic       long_len;
        logic       code_ok;
        logic       comp_used;
        logic       comp_bad;
    } fup_class_t;

    function automatic logic code_valid(input logic [3:0] code);
        return (code <= 4'd6) || ((code >= 4'd8) && (code <= 4'd12));
    endfunction

endpackage

// ===== rtl/fup_front.sv =====
// front end: takes input words and decodes the byte-level fields
module fup_front (
    input  logic               byte_valid,
    output logic               byte_stall,
    input  fup_pkg::fup_in_t   byte_data,
    input  logic               q_full,
    output logic               q_push,
    output fup_pkg::fup_class_t q_data
);
    import fup_pkg::*;

    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        q_data.in_byte    = byte_data.in_byte;
        q_data.eob        = byte_data.end_of_buffer;
        q_data.action_bad = byte_data.in_byte[1:0] != ACTION_FASTPATH;
        q_data.long_len   = byte_data.in_byte[7];
        q_data.code_ok    = code_valid(byte_data.in_byte[3:0]);
        q_data.comp_used  = byte_data.in_byte[7:6] == COMP_USED;
        // compression field of 1 or 3
        q_data.comp_bad   = byte_data.in_byte[6];
    end

endmodule

// ===== rtl/fup_queue.sv =====
// short queue of classified bytes between front and back
module fup_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fup_pkg::fup_class_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output fup_pkg::fup_class_t head
);
    import fup_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fup_class_t       store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/fup_back.sv =====
// back end: packet/record parser state machine and result register
module fup_back #(
    parameter int MAX_RECORDS = fup_pkg::MAX_RECORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  fup_pkg::fup_class_t q_head,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output fup_pkg::fup_out_t   res_data
);
    import fup_pkg::*;

    localparam int RS_W  = $clog2(MAX_RECORDS + 1);
    localparam int EXT_W = (RS_W > IDX_W) ? RS_W : IDX_W;

    fup_phase_t       phase_reg, phase_next;
    logic [LEN_W-1:0] dl_reg, dl_next;
    logic [LEN_W-1:0] bc_reg, bc_next;
    logic [RS_W-1:0]  rs_reg, rs_next;
    logic [3:0]       code_reg, code_next;
    logic [1:0]       frag_reg, frag_next;
    logic             comp_reg, comp_next;
    logic [7:0]       flags_reg, flags_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [7:0]       szlo_reg, szlo_next;
    logic [1:0]       outcome_reg, outcome_next;
    logic [1:0]       sec_reg, sec_next;
    logic [LEN_W-1:0] acc_reg, acc_next;

    logic             res_valid_reg, res_valid_next;
    fup_out_t         res_data_reg;
    fup_out_t         res_comb;

    logic             step;
    logic [7:0]       b;
    logic [LEN_W-1:0] bc_inc;
    logic [LEN_W-1:0] remaining;
    logic [15:0]      size_w;
    logic [LEN_W-1:0] left_dec;
    logic [LEN_W-1:0] short_len;
    logic [LEN_W-1:0] long_len;
    logic             sync_bad;
    logic             szhi_ok;
    logic             rec_limit;
    logic [EXT_W-1:0] rs_ext;
    logic [EXT_W-1:0] rs_ext_m1;
    logic [1:0]       outcome_step;

    assign step      = !q_empty && (!res_valid_reg || !res_stall);
    assign q_pop     = step;
    assign b         = q_head.in_byte;
    assign bc_inc    = bc_reg + LEN_W'(1);
    assign remaining = dl_reg - bc_inc;
    assign size_w    = {b, szlo_reg};
    assign left_dec  = (left_reg != '0) ? left_reg - LEN_W'(1) : '0;
    assign short_len = {7'd0, b};
    assign long_len  = {dl_reg[14:8], b};
    assign sync_bad  = (code_reg == CODE_SYNC)
                       && ((frag_reg != FRAG_SINGLE) || comp_reg || (size_w != 16'd0));
    assign szhi_ok   = (size_w <= {1'b0, remaining}) && !sync_bad;
    assign rec_limit = rs_reg >= RS_W'(MAX_RECORDS);
    assign rs_ext    = EXT_W'(rs_reg);
    assign rs_ext_m1 = rs_ext - EXT_W'(1);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        dl_next      = dl_reg;
        bc_next      = bc_reg;
        rs_next      = rs_reg;
        code_next    = code_reg;
        frag_next    = frag_reg;
        comp_next    = comp_reg;
        flags_next   = flags_reg;
        left_next    = left_reg;
        szlo_next    = szlo_reg;
        outcome_next = outcome_reg;
        sec_next     = sec_reg;
        acc_next     = acc_reg;

        case (phase_reg)
            PH_FIRST:
            begin
                bc_next = LEN_W'(1);
                if (q_head.action_bad)
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else
                begin
                    sec_next   = b[7:6];
                    phase_next = PH_LEN1;
                end
            end
            PH_LEN1:
            begin
                bc_next = LEN_W'(2);
                if (q_head.long_len)
                begin
                    dl_next    = {b[6:0], 8'h00};
                    phase_next = PH_LEN2;
                end
                else
                begin
                    dl_next = short_len;
                    if (short_len < LEN_W'(2))
                    begin
                        outcome_next = ST_PROTO_ERR;
                        phase_next   = PH_ERR;
                    end
                    else if (short_len == LEN_W'(2))
                    begin
                        outcome_next = (sec_reg != 2'd0) ? ST_SECURITY : ST_OK;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        phase_next = (sec_reg != 2'd0) ? PH_SECWAIT : PH_REC;
                    end
                end
            end
            PH_LEN2:
            begin
                bc_next = LEN_W'(3);
                dl_next = long_len;
                if (long_len < LEN_W'(3))
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else if (long_len == LEN_W'(3))
                begin
                    outcome_next = (sec_reg != 2'd0) ? ST_SECURITY : ST_OK;
                    phase_next   = PH_DONE;
                end
                else
                begin
                    phase_next = (sec_reg != 2'd0) ? PH_SECWAIT : PH_REC;
                end
            end
            PH_SECWAIT:
            begin
                bc_next = bc_inc;
                if (bc_inc >= dl_reg)
                begin
                    outcome_next = ST_SECURITY;
                    phase_next   = PH_DONE;
                end
            end
            PH_REC:
            begin
                bc_next    = bc_inc;
                code_next  = b[3:0];
                frag_next  = b[5:4];
                comp_next  = q_head.comp_used;
                flags_next = 8'd0;
                acc_next   = '0;
                if (rec_limit || !q_head.code_ok || q_head.comp_bad || (bc_inc >= dl_reg))
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else
                begin
                    phase_next = q_head.comp_used ? PH_FLAGS : PH_SZLO;
                end
            end
            PH_FLAGS:
            begin
                bc_next    = bc_inc;
                flags_next = b;
                if (bc_inc >= dl_reg)
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else
                begin
                    phase_next = PH_SZLO;
                end
            end
            PH_SZLO:
            begin
                bc_next   = bc_inc;
                szlo_next = b;
                if (bc_inc >= dl_reg)
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else
                begin
                    phase_next = PH_SZHI;
                end
            end
            PH_SZHI:
            begin
                bc_next = bc_inc;
                if (!szhi_ok)
                begin
                    outcome_next = ST_PROTO_ERR;
                    phase_next   = PH_ERR;
                end
                else
                begin
                    acc_next = size_w[LEN_W-1:0];
                    rs_next  = rs_reg + RS_W'(1);
                    if (size_w != 16'd0)
                    begin
                        left_next  = size_w[LEN_W-1:0];
                        phase_next = PH_PAY;
                    end
                    else if (bc_inc == dl_reg)
                    begin
                        outcome_next = ST_OK;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_REC;
                    end
                end
            end
            PH_PAY:
            begin
                bc_next   = bc_inc;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    if (bc_inc == dl_reg)
                    begin
                        outcome_next = ST_OK;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_REC;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // truncated packet
        if (q_head.eob && (outcome_next == ST_BUSY))
        begin
            outcome_next = ST_PROTO_ERR;
            phase_next   = PH_ERR;
        end
        outcome_step = outcome_next;

        // end of buffer starts a fresh packet
        if (q_head.eob)
        begin
            phase_next   = PH_FIRST;
            dl_next      = '0;
            bc_next      = '0;
            rs_next      = '0;
            code_next    = 4'd0;
            frag_next    = 2'd0;
            comp_next    = 1'b0;
            flags_next   = 8'd0;
            left_next    = '0;
            szlo_next    = 8'd0;
            outcome_next = ST_BUSY;
            sec_next     = 2'd0;
            acc_next     = '0;
        end
    end

    // result word
    always_comb
    begin
        res_comb                  = '0;
        res_comb.passed_byte      = b;
        res_comb.packet_status    = outcome_step;
        res_comb.byte_role        = ROLE_IGNORED;
        res_comb.update_kind      = code_reg;
        res_comb.fragment_mode    = frag_reg;
        res_comb.is_compressed    = comp_reg;
        res_comb.compress_flags   = flags_reg;
        res_comb.payload_size     = acc_reg;
        res_comb.record_index     = rs_ext[IDX_W-1:0];
        case (phase_reg)
            PH_FIRST, PH_LEN1, PH_LEN2:
            begin
                res_comb.byte_role = ROLE_PKT_HDR;
            end
            PH_REC:
            begin
                res_comb.byte_role      = ROLE_REC_HDR;
                res_comb.update_kind    = b[3:0];
                res_comb.fragment_mode  = b[5:4];
                res_comb.is_compressed  = q_head.comp_used;
                res_comb.compress_flags = 8'd0;
                res_comb.payload_size   = '0;
            end
            PH_FLAGS:
            begin
                res_comb.byte_role      = ROLE_REC_HDR;
                res_comb.compress_flags = b;
            end
            PH_SZLO:
            begin
                res_comb.byte_role = ROLE_REC_HDR;
            end
            PH_SZHI:
            begin
                res_comb.byte_role        = ROLE_REC_HDR;
                res_comb.descriptor_ready = szhi_ok;
                if (szhi_ok)
                begin
                    res_comb.payload_size = size_w[LEN_W-1:0];
                end
            end
            PH_PAY:
            begin
                res_comb.byte_role    = ROLE_PAYLOAD;
                res_comb.record_index = rs_ext_m1[IDX_W-1:0];
            end
            PH_DONE:
            begin
                res_comb.byte_role = ROLE_TRAILING;
            end
            default:
            begin
                res_comb.byte_role = ROLE_IGNORED;
            end
        endcase

        // record fields only shown on header and payload bytes
        if ((res_comb.byte_role != ROLE_REC_HDR) && (res_comb.byte_role != ROLE_PAYLOAD))
        begin
            res_comb.record_index   = '0;
            res_comb.update_kind    = 4'd0;
            res_comb.fragment_mode  = 2'd0;
            res_comb.is_compressed  = 1'b0;
            res_comb.compress_flags = 8'd0;
            res_comb.payload_size   = '0;
        end
    end

    assign res_valid_next = step || (res_valid_reg && res_stall);
    assign res_valid      = res_valid_reg;
    assign res_data       = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            dl_reg        <= '0;
            bc_reg        <= '0;
            rs_reg        <= '0;
            code_reg      <= 4'd0;
            frag_reg      <= 2'd0;
            comp_reg      <= 1'b0;
            flags_reg     <= 8'd0;
            left_reg      <= '0;
            szlo_reg      <= 8'd0;
            outcome_reg   <= ST_BUSY;
            sec_reg       <= 2'd0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (step)
            begin
                phase_reg   <= phase_next;
                dl_reg      <= dl_next;
                bc_reg      <= bc_next;
                rs_reg      <= rs_next;
                code_reg    <= code_next;
                frag_reg    <= frag_next;
                comp_reg    <= comp_next;
                flags_reg   <= flags_next;
                left_reg    <= left_next;
                szlo_reg    <= szlo_next;
                outcome_reg <= outcome_next;
                sec_reg     <= sec_next;
                acc_reg     <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_data_reg <= res_comb;
        end
    end

`ifndef ASSERT_OFF
    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |-> (outcome_reg == ST_PROTO_ERR))
        else $error("error phase without protocol error outcome");
    a_done_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> ((outcome_reg == ST_OK) || (outcome_reg == ST_SECURITY)))
        else $error("done phase without final outcome");
    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_REC) || (phase_reg == PH_FLAGS) || (phase_reg == PH_SZLO)
         || (phase_reg == PH_SZHI) || (phase_reg == PH_PAY) || (phase_reg == PH_SECWAIT))
        |-> (bc_reg < dl_reg))
        else $error("byte count reached declared length inside the packet walk");
    a_ready_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.descriptor_ready)
        |-> (res_data_reg.byte_role == ROLE_REC_HDR))
        else $error("descriptor ready on a non-header byte");
`endif

endmodule

// ===== rtl/fastpath_update_pdu_parser_unit.sv =====
// top level of the fast-path output update parser
//
// takes one byte of a received fast-path output packet per word, parses the
// packet header and walks the update records, returning one result word per
// input word: the byte's role, the record it belongs to, the record header
// fields as far as known, a descriptor-ready flag on the last header byte of
// a valid record, and the latched packet outcome; a word flagged end of
// buffer closes the packet and the next word starts a new one; throughput is
// one byte per clock while the result side does not stall, set by the parser
// step in the back end; an accepted word passes through the queue and then
// the result register before its result word appears; the four-word queue
// between the front and the back absorbs output stalls, and the input
// stalls only when it is full; no clearing pass after reset
module fastpath_update_pdu_parser_unit #(
    parameter int MAX_RECORDS = fup_pkg::MAX_RECORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  fup_pkg::fup_in_t  byte_data,
    output logic              res_valid,
    input  logic              res_stall,
    output fup_pkg::fup_out_t res_data
);
    import fup_pkg::*;

    // classified bytes between front and back
    fup_class_t q_in_data;
    fup_class_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    // front: accepts words, decodes action, length form, code and compression
    fup_front u_front (
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in_data)
    );

    // decoupling queue, lets the back stall without stopping the input at once
    fup_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back: parser state machine, one byte per step, registered result word
    fup_back #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== bench/fastpath_update_pdu_parser_unit_tb.sv =====
// testbench for the fast-path update parser: directed table, random packets, self-checking
`timescale 1ns / 100ps

module fastpath_update_pdu_parser_unit_tb;
    import fup_pkg::*;

    // run shape; the word target and thresholds are counted in accepted input words
    localparam int WORD_TARGET   = 1900;
    localparam int HOLD_AT       = 400;
    localparam int PAUSE_AT      = 1000;
    localparam int TAIL_START    = 1700;
    localparam int LONG_HOLD     = 48;
    localparam int STALL_LIMIT   = 1000;
    localparam int TABLE_ROWS    = 27;

    // update code and compression field values the checks are written against
    localparam logic [3:0] KIND_UNUSED = 4'd7;
    localparam logic [3:0] KIND_LAST   = 4'd12;
    localparam logic [1:0] COMP_NONE   = 2'd0;

    // ways a random packet can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_ACTION,
        FLAW_SHORT_LEN,
        FLAW_LEN_SKEW,
        FLAW_KIND,
        FLAW_COMP,
        FLAW_SYNC,
        FLAW_CUT,
        FLAW_SECURITY,
        FLAW_NOISE
    } flaw_t;

    // role and status typed into the table, checked on top of the prediction
    typedef struct packed {
        logic       pinned;
        logic [2:0] role;
        logic [1:0] status;
    } pin_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       eob;
        pin_t       pin;
    } table_row_t;

    typedef struct packed {
        fup_out_t want;
        pin_t     pin;
    } expected_word_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    fup_in_t   byte_data;
    logic      res_valid;
    logic      res_stall;
    fup_out_t  res_data;

    fastpath_update_pdu_parser_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // directed part: header errors, security skip, a clean long-form packet with
    // a sync record and a compressed record, bad code and compression, longest length
    table_row_t stim_table [TABLE_ROWS] = '{
        // bad action, then a byte ignored after the error
        '{8'h01, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_PROTO_ERR}},
        '{8'hff, 1'b1, '{1'b1, ROLE_IGNORED,  ST_PROTO_ERR}},
        // declared length shorter than the header
        '{8'h00, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_BUSY}},
        '{8'h01, 1'b1, '{1'b1, ROLE_PKT_HDR,  ST_PROTO_ERR}},
        // security flags set, body skipped up to the declared length
        '{8'hc0, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_BUSY}},
        '{8'h04, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_BUSY}},
        '{8'h11, 1'b0, '{1'b1, ROLE_IGNORED,  ST_BUSY}},
        '{8'h22, 1'b1, '{1'b1, ROLE_IGNORED,  ST_SECURITY}},
        // long form length 12: sync record, compressed record with two payload bytes
        '{8'h3c, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_BUSY}},
        '{8'h80, 1'b0, '0},
        '{8'h0c, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h81, 1'b0, '0},
        '{8'hff, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hab, 1'b0, '0},
        '{8'h00, 1'b0, '{1'b1, ROLE_PAYLOAD,  ST_OK}},
        '{8'hee, 1'b1, '{1'b1, ROLE_TRAILING, ST_OK}},
        // record header with a reserved code and a bad compression field
        '{8'h00, 1'b0, '{1'b1, ROLE_PKT_HDR,  ST_BUSY}},
        '{8'h06, 1'b0, '0},
        '{8'h4d, 1'b1, '{1'b1, ROLE_REC_HDR,  ST_PROTO_ERR}},
        // longest declared length, buffer closed right after the header
        '{8'h00, 1'b0, '0},
        '{8'hff, 1'b0, '0},
        '{8'hff, 1'b1, '{1'b1, ROLE_PKT_HDR,  ST_PROTO_ERR}}
    };

    // ---------------------------------------------------------------
    // parser state as the predictor sees it
    // ---------------------------------------------------------------
    fup_phase_t  ph;
    int unsigned decl_len;
    int unsigned consumed;
    int unsigned recs;
    int unsigned pay_left;
    int unsigned acc_size;
    logic [7:0]  size_lo;
    logic [3:0]  rec_kind;
    logic [1:0]  rec_frag;
    logic        rec_comp;
    logic [7:0]  rec_flags;
    logic [1:0]  outcome;
    logic [1:0]  sec_flags;

    // scoreboard and bookkeeping
    expected_word_t expected_words [$];
    fup_in_t        byte_plan [$];
    pin_t           cur_pin;
    int             mismatches;
    int             words_sent;
    int             results_seen;
    int             descriptors;
    int             buffers_ok;
    int             buffers_err;
    int             buffers_sec;

    // knobs shared between the sender and the receiver
    int             idle_odds;
    bit             quiet_tail;
    bit             hold_wanted;

    // whole packet state back to idle, as at reset and after end of buffer
    function automatic void parser_clear();
        ph        = PH_FIRST;
        decl_len  = 0;
        consumed  = 0;
        recs      = 0;
        pay_left  = 0;
        acc_size  = 0;
        size_lo   = '0;
        rec_kind  = '0;
        rec_frag  = '0;
        rec_comp  = 1'b0;
        rec_flags = '0;
        outcome   = ST_BUSY;
        sec_flags = '0;
    endfunction

    function automatic void fail_packet();
        outcome = ST_PROTO_ERR;
        ph      = PH_ERR;
    endfunction

    // between records: either the packet is used up or another header follows
    function automatic void record_boundary();
        if (consumed == decl_len) begin
            outcome = ST_OK;
            ph      = PH_DONE;
        end else begin
            ph = PH_REC;
        end
    endfunction

    function automatic void header_end(input int unsigned hlen);
        if (decl_len < hlen) begin
            fail_packet();
        end else if (sec_flags != 2'b00) begin
            if (consumed == decl_len) begin
                outcome = ST_SECURITY;
                ph      = PH_DONE;
            end else begin
                ph = PH_SECWAIT;
            end
        end else begin
            record_boundary();
        end
    endfunction

    // a record header byte that leaves nothing for the rest of the header
    function automatic void check_room();
        if (ph != PH_ERR && consumed >= decl_len)
            fail_packet();
    endfunction

    // one parser step: the result word caused by one input word
    function automatic fup_out_t parse_step(input fup_in_t w);
        fup_out_t    r;
        logic [2:0]  role;
        int unsigned idx;
        int unsigned size;
        logic [1:0]  comp;
        logic        ready;
        role  = ROLE_IGNORED;
        idx   = 0;
        ready = 1'b0;
        case (ph)
            PH_FIRST: begin
                role     = ROLE_PKT_HDR;
                consumed = 1;
                if (w.in_byte[1:0] != ACTION_FASTPATH) begin
                    fail_packet();
                end else begin
                    sec_flags = w.in_byte[7:6];
                    ph        = PH_LEN1;
                end
            end
            PH_LEN1: begin
                role     = ROLE_PKT_HDR;
                consumed = 2;
                if (w.in_byte[7]) begin
                    decl_len = {w.in_byte[6:0], 8'h00};
                    ph       = PH_LEN2;
                end else begin
                    decl_len = w.in_byte;
                    header_end(2);
                end
            end
            PH_LEN2: begin
                role     = ROLE_PKT_HDR;
                consumed = 3;
                decl_len = decl_len | w.in_byte;
                header_end(3);
            end
            PH_SECWAIT: begin
                role     = ROLE_IGNORED;
                consumed = consumed + 1;
                if (consumed >= decl_len) begin
                    outcome = ST_SECURITY;
                    ph      = PH_DONE;
                end
            end
            PH_REC: begin
                role      = ROLE_REC_HDR;
                idx       = recs;
                consumed  = consumed + 1;
                rec_kind  = w.in_byte[3:0];
                rec_frag  = w.in_byte[5:4];
                comp      = w.in_byte[7:6];
                rec_comp  = (comp == COMP_USED);
                rec_flags = '0;
                acc_size  = 0;
                if (recs >= MAX_RECORDS_DEF || rec_kind == KIND_UNUSED ||
                    rec_kind > KIND_LAST || (comp != COMP_NONE && comp != COMP_USED)) begin
                    fail_packet();
                end else begin
                    ph = rec_comp ? PH_FLAGS : PH_SZLO;
                    check_room();
                end
            end
            PH_FLAGS: begin
                role      = ROLE_REC_HDR;
                idx       = recs;
                consumed  = consumed + 1;
                rec_flags = w.in_byte;
                ph        = PH_SZLO;
                check_room();
            end
            PH_SZLO: begin
                role     = ROLE_REC_HDR;
                idx      = recs;
                consumed = consumed + 1;
                size_lo  = w.in_byte;
                ph       = PH_SZHI;
                check_room();
            end
            PH_SZHI: begin
                role     = ROLE_REC_HDR;
                idx      = recs;
                consumed = consumed + 1;
                size     = {w.in_byte, size_lo};
                if (size > decl_len - consumed) begin
                    fail_packet();
                end else if (rec_kind == CODE_SYNC &&
                             (rec_frag != FRAG_SINGLE || rec_comp || size != 0)) begin
                    fail_packet();
                end else begin
                    acc_size = size;
                    ready    = 1'b1;
                    recs     = recs + 1;
                    if (size > 0) begin
                        pay_left = size;
                        ph       = PH_PAY;
                    end else begin
                        record_boundary();
                    end
                end
            end
            PH_PAY: begin
                role     = ROLE_PAYLOAD;
                idx      = recs - 1;
                consumed = consumed + 1;
                if (pay_left > 0)
                    pay_left = pay_left - 1;
                if (pay_left == 0)
                    record_boundary();
            end
            PH_DONE: begin
                role = ROLE_TRAILING;
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        // a buffer closing before any outcome counts as truncation
        if (w.end_of_buffer && outcome == ST_BUSY)
            fail_packet();

        r                  = '0;
        r.byte_role        = role;
        r.passed_byte      = w.in_byte;
        r.descriptor_ready = ready;
        r.packet_status    = outcome;
        if (role == ROLE_REC_HDR || role == ROLE_PAYLOAD) begin
            r.record_index   = idx[IDX_W-1:0];
            r.update_kind    = rec_kind;
            r.fragment_mode  = rec_frag;
            r.is_compressed  = rec_comp;
            r.compress_flags = rec_flags;
            r.payload_size   = acc_size[LEN_W-1:0];
        end

        if (w.end_of_buffer)
            parser_clear();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    // one line per mismatch
    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned want);
        if (got !== want) begin
            $display("mismatch on %s at result word %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
            mismatches++;
        end
    endtask

    task automatic check_word(input fup_out_t got);
        expected_word_t e;
        if (expected_words.size() == 0) begin
            check_field("pending expectations", 0, 1);
        end else begin
            e = expected_words.pop_front();
            check_field("byte_role",        got.byte_role,        e.want.byte_role);
            check_field("passed_byte",      got.passed_byte,      e.want.passed_byte);
            check_field("record_index",     got.record_index,     e.want.record_index);
            check_field("descriptor_ready", got.descriptor_ready, e.want.descriptor_ready);
            check_field("update_kind",      got.update_kind,      e.want.update_kind);
            check_field("fragment_mode",    got.fragment_mode,    e.want.fragment_mode);
            check_field("is_compressed",    got.is_compressed,    e.want.is_compressed);
            check_field("compress_flags",   got.compress_flags,   e.want.compress_flags);
            check_field("payload_size",     got.payload_size,     e.want.payload_size);
            check_field("packet_status",    got.packet_status,    e.want.packet_status);
            // table rows also hold the block to the hand-written role and status
            if (e.pin.pinned) begin
                check_field("byte_role per table",     got.byte_role,     e.pin.role);
                check_field("packet_status per table", got.packet_status, e.pin.status);
            end
        end
        if (got.descriptor_ready)
            descriptors++;
        results_seen++;
    endtask

    // everything is sampled at the rising edge: result words are checked first,
    // then an accepted input word is run through the predictor
    always @(posedge clk) begin : monitor
        expected_word_t e;
        if (rst_n) begin
            if (res_valid && !res_stall)
                check_word(res_data);
            if (byte_valid && !byte_stall) begin
                e.want = parse_step(byte_data);
                e.pin  = cur_pin;
                expected_words.push_back(e);
                if (byte_data.end_of_buffer) begin
                    if (e.want.packet_status == ST_OK)
                        buffers_ok++;
                    else if (e.want.packet_status == ST_SECURITY)
                        buffers_sec++;
                    else
                        buffers_err++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // clock, watchdog, receiver
    // ---------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // gives up when no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("fastpath_update_pdu_parser_unit test failed");
        $finish;
    end

    // result side: short random stalls, one long hold-off on request, none at the tail
    initial begin : receiver
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                res_stall <= 1'b0;
            end else if (!quiet_tail && idle_odds != 0 &&
                         $urandom_range(0, 9) < idle_odds) begin
                n = $urandom_range(1, 3);
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // offers one word at the falling edge, sometimes after a short gap, and
    // returns at the falling edge after it was taken
    task automatic send_word(input fup_in_t w);
        int gap;
        if (!quiet_tail && idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
            gap = $urandom_range(1, 3);
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= w;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // builds one buffer into the plan: mostly well-formed packets with random
    // records, some spoiled in one place, some pure noise
    task automatic plan_packet();
        logic [7:0]  body [$];
        logic [7:0]  pkt [$];
        fup_in_t     w;
        flaw_t       flaw;
        int          n_rec;
        int          bad_rec;
        int          size;
        int          decl;
        int          hlen;
        int          j;
        bit          crowd;
        bit          long_form;
        logic [3:0]  kind;
        logic [1:0]  frag;
        logic [1:0]  comp_field;
        logic [1:0]  sec;
        logic [1:0]  action;
        logic [14:0] decl_bits;

        if ($urandom_range(0, 9) < 7)
            flaw = FLAW_NONE;
        else
            flaw = flaw_t'($urandom_range(FLAW_ACTION, FLAW_NOISE));

        if (flaw == FLAW_NOISE) begin
            n_rec = $urandom_range(1, 12);
            for (j = 0; j < n_rec; j++)
                pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
            // record count: usually a few, sometimes none, rarely the full table or one over
            crowd = ($urandom_range(0, 29) == 0);
            if (crowd)
                n_rec = MAX_RECORDS_DEF + $urandom_range(0, 1);
            else if (flaw == FLAW_NONE && $urandom_range(0, 9) == 0)
                n_rec = 0;
            else
                n_rec = $urandom_range(1, 4);
            bad_rec = (n_rec > 0) ? $urandom_range(0, n_rec - 1) : -1;

            for (j = 0; j < n_rec; j++) begin
                do
                    kind = 4'($urandom_range(0, 15));
                while (kind == KIND_UNUSED || kind > KIND_LAST);
                frag       = 2'($urandom_range(0, 3));
                comp_field = $urandom_range(0, 1) ? COMP_USED : COMP_NONE;
                if (crowd || $urandom_range(0, 3) == 0)
                    size = 0;
                else if ($urandom_range(0, 79) == 0)
                    size = $urandom_range(20, 200);
                else
                    size = $urandom_range(1, 6);
                // a well-formed sync record is single, uncompressed and empty
                if (kind == CODE_SYNC) begin
                    frag       = FRAG_SINGLE;
                    comp_field = COMP_NONE;
                    size       = 0;
                end
                if (j == bad_rec) begin
                    case (flaw)
                        FLAW_KIND: begin
                            if ($urandom_range(0, 3) == 0)
                                kind = KIND_UNUSED;
                            else
                                kind = 4'($urandom_range(13, 15));
                        end
                        FLAW_COMP: begin
                            // 01 or 11, both reserved
                            comp_field = {1'($urandom_range(0, 1)), 1'b1};
                        end
                        FLAW_SYNC: begin
                            kind = CODE_SYNC;
                            case ($urandom_range(0, 2))
                                0:       frag = 2'($urandom_range(1, 3));
                                1:       comp_field = COMP_USED;
                                default: size = $urandom_range(1, 4);
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
                body.push_back({comp_field, frag, kind});
                if (comp_field == COMP_USED)
                    body.push_back(8'($urandom_range(0, 255)));
                body.push_back(size[7:0]);
                body.push_back(size[15:8]);
                repeat (size) body.push_back(8'($urandom_range(0, 255)));
            end

            long_form = (body.size() + 8 > 127) || ($urandom_range(0, 3) == 0);
            hlen      = long_form ? 3 : 2;
            decl      = hlen + body.size();
            case (flaw)
                FLAW_SHORT_LEN: decl = $urandom_range(0, hlen - 1);
                FLAW_LEN_SKEW: begin
                    // shorter runs a header or payload past the end, longer truncates
                    if ($urandom_range(0, 1))
                        decl = decl + $urandom_range(1, 4);
                    else
                        decl = decl - $urandom_range(1, 4);
                    if (decl < 0)
                        decl = 0;
                end
                FLAW_SECURITY: begin
                    if (long_form && $urandom_range(0, 2) == 0)
                        decl = $urandom_range(0, 32767);
                end
                default: begin
                end
            endcase
            decl_bits = 15'(decl);

            sec    = (flaw == FLAW_SECURITY) ? 2'($urandom_range(1, 3)) : 2'b00;
            action = (flaw == FLAW_ACTION) ? 2'($urandom_range(1, 3)) : ACTION_FASTPATH;
            // unused bits of the first byte are random too
            pkt.push_back({sec, 4'($urandom_range(0, 15)), action});
            if (long_form) begin
                pkt.push_back({1'b1, decl_bits[14:8]});
                pkt.push_back(decl_bits[7:0]);
            end else begin
                pkt.push_back({1'b0, decl_bits[6:0]});
            end
            pkt = {pkt, body};

            if (flaw == FLAW_CUT && pkt.size() > 1)
                pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
            else if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
        end

        // end of buffer rides on the last byte
        for (j = 0; j < pkt.size(); j++) begin
            w.in_byte       = pkt[j];
            w.end_of_buffer = (j == pkt.size() - 1);
            byte_plan.push_back(w);
        end
    endtask

    initial begin : stimulus
        int  r;
        bit  hold_done;
        bit  pause_done;
        byte_valid   = 1'b0;
        byte_data    = '0;
        rst_n        = 1'b0;
        cur_pin      = '0;
        mismatches   = 0;
        words_sent   = 0;
        results_seen = 0;
        descriptors  = 0;
        buffers_ok   = 0;
        buffers_err  = 0;
        buffers_sec  = 0;
        idle_odds    = 2;
        quiet_tail   = 1'b0;
        hold_wanted  = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        parser_clear();

        // reset asserted at the start, released on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (r = 0; r < TABLE_ROWS; r++) begin
            cur_pin = stim_table[r].pin;
            send_word({stim_table[r].in_byte, stim_table[r].eob});
        end
        cur_pin = '0;

        // random packets until the word budget is spent
        while (words_sent < WORD_TARGET) begin
            idle_odds  = $urandom_range(0, 3);
            quiet_tail = (words_sent >= TAIL_START);
            plan_packet();
            while (byte_plan.size() != 0) begin
                // receiver holds off long enough for the block to fill and stall its input
                if (!hold_done && words_sent >= HOLD_AT) begin
                    hold_done   = 1'b1;
                    hold_wanted = 1'b1;
                end
                // sender goes quiet until every expected word is back
                if (!pause_done && words_sent >= PAUSE_AT) begin
                    pause_done = 1'b1;
                    byte_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (expected_words.size() != 0);
                end
                send_word(byte_plan.pop_front());
            end
        end
        byte_valid <= 1'b0;

        // drain, then keep clocking to catch any stray result word
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        check_field("words still expected at the end", expected_words.size(), 0);

        $display("run covered %0d words and %0d buffers, %0d record descriptors seen",
                 words_sent, buffers_ok + buffers_err + buffers_sec, descriptors);
        $display("buffers closed: %0d parsed, %0d protocol error, %0d security; %0d mismatches",
                 buffers_ok, buffers_err, buffers_sec, mismatches);
        if (mismatches == 0)
            $display("fastpath_update_pdu_parser_unit test passed");
        else
            $display("fastpath_update_pdu_parser_unit test failed");
        $finish;
    end

endmodule
